// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros for the segment allocator checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFSA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BFSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfsa_pkg.sv =====
`default_nettype none

package bfsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SPACE_BITS   = 16;

    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SZ_W    = SPACE_BITS + 1;
    localparam int ARITH_W = SPACE_BITS + 3;

    // fixed field widths
    localparam int MIN_W   = 13;
    localparam int OWNER_W = 64;
    localparam int OFF_W   = 16;
    localparam int LINES_W = 17;

    localparam logic [MIN_W-1:0]   MIN_RESET   = MIN_W'(8);
    localparam logic [ARITH_W-1:0] SPACE_LIMIT = ARITH_W'(1) << SPACE_BITS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_SPACE  = 3'd4;

    typedef struct packed {
        logic               op;
        logic [OWNER_W-1:0] owner_id;
        logic [OFF_W-1:0]   query_offset;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [OFF_W-1:0]   record_offset;
        logic               move_valid;
        logic [OFF_W-1:0]   move_from;
        logic [OFF_W-1:0]   move_to;
        logic [OFF_W-1:0]   move_count;
        logic [OWNER_W-1:0] seg_owner;
        logic [LINES_W-1:0] seg_lines;
        logic [LINES_W-1:0] seg_used;
        logic               seg_is_free;
    } res_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [SZ_W-1:0]    size;
        logic [SZ_W-1:0]    used;
        logic               free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // table edit list, carried out in order by the sequencer
    typedef struct packed {
        logic             finish;
        logic             pass2;
        logic             up_en;
        logic [IDX_W-1:0] up_pos;
        entry_t           up_ent;
        logic             w1_en;
        logic [IDX_W-1:0] w1_addr;
        entry_t           w1_ent;
        logic             w2_en;
        logic [IDX_W-1:0] w2_addr;
        entry_t           w2_ent;
        logic             dn_en;
        logic [IDX_W-1:0] dn_pos;
        logic             ap_en;
        entry_t           ap_ent;
        res_t             res;
    } plan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SH_UP,
        S_WR_UP,
        S_WR1,
        S_WR2,
        S_SH_DN,
        S_APPEND,
        S_DONE
    } seq_state_t;

    function automatic entry_t make_entry(input logic [OWNER_W-1:0] owner,
                                          input logic [ARITH_W-1:0] size,
                                          input logic [ARITH_W-1:0] used,
                                          input logic               free);
        entry_t e;
        e.owner = owner;
        e.size  = SZ_W'(size);
        e.used  = SZ_W'(used);
        e.free  = free;
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/best_fit_segment_allocator_core.sv =====
`default_nettype none

// Best-fit segment allocator. An address-ordered table of up to MAX_SEGMENTS
// segments (owner, size, used count, free flag) sits in one single-port-write
// RAM with a registered read. An insert request scans the table once, one
// entry a cycle, to find the owner, its neighbors, the table end and the
// best-fit free segment; a full segment that must move scans a second time
// for a free segment of twice its size. Table edits (open a slot, up to two
// entry writes, close a slot, append) then run one entry a cycle, since
// splitting and coalescing shift the tail of the table. One request is in
// flight at a time; the next request is taken while the last result still
// waits in the output register. The user must write min_segment_lines on the
// cfg channel only while idle; the block itself does not enforce this. Zero
// acts as one.
module best_fit_segment_allocator_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bfsa_pkg::req_t                 s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bfsa_pkg::res_t                      m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bfsa_pkg::MIN_W-1:0]     cfg_data
);

    localparam int IDX_W   = bfsa_pkg::IDX_W;
    localparam int CNT_W   = bfsa_pkg::CNT_W;
    localparam int SZ_W    = bfsa_pkg::SZ_W;
    localparam int ARITH_W = bfsa_pkg::ARITH_W;

    // sequencer
    bfsa_pkg::seq_state_t state_reg, state_next;

    // request and config
    bfsa_pkg::req_t             req_reg;
    logic [bfsa_pkg::MIN_W-1:0] min_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       pass2_reg;

    // table scan
    logic [CNT_W-1:0]   rd_ptr_reg;
    logic               ev_valid_reg;
    logic [IDX_W-1:0]   ev_idx_reg;
    logic [ARITH_W-1:0] acc_reg;

    // owner hit and its neighbors
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [ARITH_W-1:0] hit_off_reg;
    logic [SZ_W-1:0]    hit_size_reg;
    logic [SZ_W-1:0]    hit_used_reg;
    logic               prev_free_reg;
    logic [SZ_W-1:0]    prev_size_reg;
    logic               last_free_reg;
    logic [SZ_W-1:0]    last_size_reg;
    logic               next_free_reg;
    logic [SZ_W-1:0]    next_size_reg;

    // best fit
    logic               bf_found_reg;
    logic [IDX_W-1:0]   bf_idx_reg;
    logic [ARITH_W-1:0] bf_off_reg;
    logic [SZ_W-1:0]    bf_size_reg;
    logic [ARITH_W-1:0] need_reg;

    // query
    logic                    q_found_reg;
    bfsa_pkg::entry_t        q_ent_reg;

    // edit plan and shifter
    bfsa_pkg::plan_t  plan_reg;
    bfsa_pkg::plan_t  plan;
    logic [IDX_W-1:0] sh_rd_reg;
    logic [CNT_W-1:0] sh_left_reg;
    logic             sh_wv_reg;
    logic [IDX_W-1:0] sh_wa_reg;

    // results
    bfsa_pkg::res_t res_reg;
    bfsa_pkg::res_t out_reg;
    logic           out_valid_reg;

    // table ram
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [bfsa_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [bfsa_pkg::ENTRY_W-1:0] ram_rdata;
    bfsa_pkg::entry_t             ev_ent;

    bfsa_ram #(
        .WIDTH (bfsa_pkg::ENTRY_W),
        .DEPTH (bfsa_pkg::MAX_SEGMENTS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ev_ent = bfsa_pkg::entry_t'(ram_rdata);

    // scan datapath
    logic               scan_issue;
    logic               scan_done;
    logic               sh_done;
    logic [ARITH_W-1:0] acc_next;
    logic [ARITH_W-1:0] q_off;
    logic               bf_hit;
    logic               q_hit;
    logic               own_hit;
    logic               accept;

    assign scan_issue = rd_ptr_reg < count_reg;
    assign scan_done  = !scan_issue && !ev_valid_reg;
    assign sh_done    = (sh_left_reg == '0) && !sh_wv_reg;
    assign acc_next   = acc_reg + ARITH_W'(ev_ent.size);
    assign q_off      = ARITH_W'(req_reg.query_offset);
    assign bf_hit     = ev_ent.free && (ARITH_W'(ev_ent.size) >= need_reg) &&
                        (!bf_found_reg || (bf_size_reg > ev_ent.size));
    assign q_hit      = (q_off >= acc_reg) && (q_off < acc_next);
    assign own_hit    = !ev_ent.free && (ev_ent.owner == req_reg.owner_id);
    assign accept     = s_valid && s_ready;

    // decision operands
    logic [ARITH_W-1:0] a_m, two_m, a_size, a_used, a_nsize, a_psize, a_bsize, a_off;
    logic [ARITH_W-1:0] a_end, a_used1;
    logic               full, has_next, i_gt0, j_left, j_lt_i;

    assign a_m      = ARITH_W'(min_reg);
    assign two_m    = a_m << 1;
    assign a_size   = ARITH_W'(hit_size_reg);
    assign a_used   = ARITH_W'(hit_used_reg);
    assign a_used1  = a_used + ARITH_W'(1);
    assign a_nsize  = ARITH_W'(next_size_reg);
    assign a_psize  = ARITH_W'(prev_size_reg);
    assign a_bsize  = ARITH_W'(bf_size_reg);
    assign a_off    = hit_off_reg;
    assign a_end    = acc_reg;
    assign full     = count_reg >= CNT_W'(bfsa_pkg::MAX_SEGMENTS);
    assign has_next = (CNT_W'(hit_idx_reg) + CNT_W'(1)) < count_reg;
    assign i_gt0    = hit_idx_reg != '0;
    assign j_left   = (CNT_W'(bf_idx_reg) + CNT_W'(1)) == CNT_W'(hit_idx_reg);
    assign j_lt_i   = bf_idx_reg < hit_idx_reg;

    // what to do with the table once a scan is complete
    always_comb begin
        logic               split;
        logic               lmerge;
        logic [IDX_W-1:0]   ip;
        logic [ARITH_W-1:0] lsize;
        logic [ARITH_W-1:0] fo;
        logic [CNT_W-1:0]   cnt_after;
        split     = 1'b0;
        lmerge    = 1'b0;
        ip        = hit_idx_reg;
        lsize     = a_psize;
        fo        = a_end;
        cnt_after = count_reg;
        plan      = '0;
        plan.res.status = bfsa_pkg::ST_OK;
        if (req_reg.op == bfsa_pkg::OP_QUERY) begin
            plan.finish = 1'b1;
            if (q_found_reg) begin
                plan.res.seg_owner   = q_ent_reg.free ? '0 : q_ent_reg.owner;
                plan.res.seg_lines   = bfsa_pkg::LINES_W'(q_ent_reg.size);
                plan.res.seg_used    = q_ent_reg.free ? '0 :
                                       bfsa_pkg::LINES_W'(q_ent_reg.used);
                plan.res.seg_is_free = q_ent_reg.free;
            end else begin
                plan.res.status = bfsa_pkg::ST_NOT_FOUND;
            end
        end else if (!pass2_reg) begin
            if (!hit_reg) begin
                // new owner
                if (bf_found_reg) begin
                    split = a_bsize >= two_m;
                    if (split && full) begin
                        plan.finish     = 1'b1;
                        plan.res.status = bfsa_pkg::ST_FULL;
                    end else begin
                        plan.up_en   = split;
                        plan.up_pos  = bf_idx_reg + IDX_W'(1);
                        plan.up_ent  = bfsa_pkg::make_entry('0, a_bsize - a_m, '0, 1'b1);
                        plan.w1_en   = 1'b1;
                        plan.w1_addr = bf_idx_reg;
                        plan.w1_ent  = bfsa_pkg::make_entry(req_reg.owner_id,
                                           split ? a_m : a_bsize, ARITH_W'(1), 1'b0);
                        plan.res.record_offset = bfsa_pkg::OFF_W'(bf_off_reg);
                    end
                end else if (full) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_FULL;
                end else if (a_end + a_m > bfsa_pkg::SPACE_LIMIT) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_NO_SPACE;
                end else begin
                    plan.ap_en  = 1'b1;
                    plan.ap_ent = bfsa_pkg::make_entry(req_reg.owner_id, a_m,
                                                       ARITH_W'(1), 1'b0);
                    plan.res.record_offset = bfsa_pkg::OFF_W'(a_end);
                end
            end else if (a_used < a_size) begin
                // room left in the segment
                plan.w1_en   = 1'b1;
                plan.w1_addr = hit_idx_reg;
                plan.w1_ent  = bfsa_pkg::make_entry(req_reg.owner_id, a_size, a_used1, 1'b0);
                plan.res.record_offset = bfsa_pkg::OFF_W'(a_off + a_used);
            end else if (has_next && next_free_reg) begin
                // grow into the free right neighbor
                plan.w1_en = 1'b1;
                if (a_nsize >= two_m) begin
                    plan.w1_addr = hit_idx_reg + IDX_W'(1);
                    plan.w1_ent  = bfsa_pkg::make_entry('0, a_nsize - a_m, '0, 1'b1);
                    plan.w2_en   = 1'b1;
                    plan.w2_addr = hit_idx_reg;
                    plan.w2_ent  = bfsa_pkg::make_entry(req_reg.owner_id, a_size + a_m,
                                                        a_used1, 1'b0);
                end else begin
                    plan.w1_addr = hit_idx_reg;
                    plan.w1_ent  = bfsa_pkg::make_entry(req_reg.owner_id, a_size + a_nsize,
                                                        a_used1, 1'b0);
                    plan.dn_en   = 1'b1;
                    plan.dn_pos  = hit_idx_reg + IDX_W'(1);
                end
                plan.res.record_offset = bfsa_pkg::OFF_W'(a_off + a_used);
            end else if (!has_next) begin
                // last segment grows at the end of space
                if (a_off + a_size + a_m > bfsa_pkg::SPACE_LIMIT) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_NO_SPACE;
                end else begin
                    plan.w1_en   = 1'b1;
                    plan.w1_addr = hit_idx_reg;
                    plan.w1_ent  = bfsa_pkg::make_entry(req_reg.owner_id, a_size + a_m,
                                                        a_used1, 1'b0);
                    plan.res.record_offset = bfsa_pkg::OFF_W'(a_off + a_used);
                end
            end else begin
                plan.pass2 = 1'b1;
            end
        end else begin
            // move to a segment of twice the size, then free the old one
            if (bf_found_reg) begin
                fo     = bf_off_reg;
                split  = (a_bsize - need_reg) >= a_m;
                ip     = hit_idx_reg + IDX_W'(split && j_lt_i);
                lmerge = j_left ? split : (i_gt0 && prev_free_reg);
                lsize  = j_left ? (a_bsize - need_reg) : a_psize;
                if (split && full) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_FULL;
                end else begin
                    plan.up_en   = split;
                    plan.up_pos  = bf_idx_reg + IDX_W'(1);
                    plan.up_ent  = bfsa_pkg::make_entry('0, a_bsize - need_reg, '0, 1'b1);
                    plan.w1_en   = 1'b1;
                    plan.w1_addr = bf_idx_reg;
                    plan.w1_ent  = bfsa_pkg::make_entry(req_reg.owner_id,
                                       split ? need_reg : a_bsize, a_used1, 1'b0);
                    plan.w2_en   = 1'b1;
                    if (lmerge) begin
                        plan.w2_addr = ip - IDX_W'(1);
                        plan.w2_ent  = bfsa_pkg::make_entry('0, lsize + a_size, '0, 1'b1);
                        plan.dn_en   = 1'b1;
                        plan.dn_pos  = ip;
                    end else begin
                        plan.w2_addr = ip;
                        plan.w2_ent  = bfsa_pkg::make_entry('0, a_size, '0, 1'b1);
                    end
                end
            end else begin
                lmerge    = i_gt0 && prev_free_reg;
                cnt_after = count_reg - CNT_W'(lmerge);
                if (a_end + need_reg > bfsa_pkg::SPACE_LIMIT) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_NO_SPACE;
                end else if (cnt_after >= CNT_W'(bfsa_pkg::MAX_SEGMENTS)) begin
                    plan.finish     = 1'b1;
                    plan.res.status = bfsa_pkg::ST_FULL;
                end else begin
                    plan.w2_en = 1'b1;
                    if (lmerge) begin
                        plan.w2_addr = hit_idx_reg - IDX_W'(1);
                        plan.w2_ent  = bfsa_pkg::make_entry('0, a_psize + a_size, '0, 1'b1);
                        plan.dn_en   = 1'b1;
                        plan.dn_pos  = hit_idx_reg;
                    end else begin
                        plan.w2_addr = hit_idx_reg;
                        plan.w2_ent  = bfsa_pkg::make_entry('0, a_size, '0, 1'b1);
                    end
                    plan.ap_en  = 1'b1;
                    plan.ap_ent = bfsa_pkg::make_entry(req_reg.owner_id, need_reg,
                                                       a_used1, 1'b0);
                end
            end
            if (plan.res.status == bfsa_pkg::ST_OK) begin
                plan.res.move_valid    = 1'b1;
                plan.res.move_from     = bfsa_pkg::OFF_W'(a_off);
                plan.res.move_to       = bfsa_pkg::OFF_W'(fo);
                plan.res.move_count    = bfsa_pkg::OFF_W'(a_used);
                plan.res.record_offset = bfsa_pkg::OFF_W'(fo + a_used);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bfsa_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == bfsa_pkg::OP_INSERT && s_data.owner_id == '0) begin
                        state_next = bfsa_pkg::S_DONE;
                    end else begin
                        state_next = bfsa_pkg::S_SCAN;
                    end
                end
            end
            bfsa_pkg::S_SCAN: begin
                if (scan_done) begin
                    state_next = bfsa_pkg::S_DECIDE;
                end
            end
            bfsa_pkg::S_DECIDE: begin
                if (plan.finish) begin
                    state_next = bfsa_pkg::S_DONE;
                end else if (plan.pass2) begin
                    state_next = bfsa_pkg::S_SCAN;
                end else begin
                    state_next = bfsa_pkg::S_SH_UP;
                end
            end
            bfsa_pkg::S_SH_UP: begin
                if (sh_done) begin
                    state_next = bfsa_pkg::S_WR_UP;
                end
            end
            bfsa_pkg::S_WR_UP: state_next = bfsa_pkg::S_WR1;
            bfsa_pkg::S_WR1:   state_next = bfsa_pkg::S_WR2;
            bfsa_pkg::S_WR2:   state_next = bfsa_pkg::S_SH_DN;
            bfsa_pkg::S_SH_DN: begin
                if (sh_done) begin
                    state_next = bfsa_pkg::S_APPEND;
                end
            end
            bfsa_pkg::S_APPEND: state_next = bfsa_pkg::S_DONE;
            bfsa_pkg::S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = bfsa_pkg::S_IDLE;
                end
            end
            default: state_next = bfsa_pkg::S_IDLE;
        endcase
    end

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = plan_reg.w1_addr;
        ram_wdata = plan_reg.w1_ent;
        ram_raddr = rd_ptr_reg[IDX_W-1:0];
        case (state_reg)
            bfsa_pkg::S_SH_UP, bfsa_pkg::S_SH_DN: begin
                ram_raddr = sh_rd_reg;
                ram_we    = sh_wv_reg;
                ram_waddr = sh_wa_reg;
                ram_wdata = ram_rdata;
            end
            bfsa_pkg::S_WR_UP: begin
                ram_we    = plan_reg.up_en;
                ram_waddr = plan_reg.up_pos;
                ram_wdata = plan_reg.up_ent;
            end
            bfsa_pkg::S_WR1: begin
                ram_we    = plan_reg.w1_en;
                ram_waddr = plan_reg.w1_addr;
                ram_wdata = plan_reg.w1_ent;
            end
            bfsa_pkg::S_WR2: begin
                ram_we    = plan_reg.w2_en;
                ram_waddr = plan_reg.w2_addr;
                ram_wdata = plan_reg.w2_ent;
            end
            bfsa_pkg::S_APPEND: begin
                ram_we    = plan_reg.ap_en;
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = plan_reg.ap_ent;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign s_ready   = (state_reg == bfsa_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bfsa_pkg::S_IDLE;
            min_reg       <= bfsa_pkg::MIN_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            sh_wv_reg     <= 1'b0;
            sh_left_reg   <= '0;
        end else begin
            state_reg <= state_next;

            // zero acts as one
            if (cfg_valid && cfg_ready) begin
                min_reg <= (cfg_data == '0) ? bfsa_pkg::MIN_W'(1) : cfg_data;
            end

            case (state_reg)
                bfsa_pkg::S_IDLE: begin
                    if (accept) begin
                        req_reg       <= s_data;
                        pass2_reg     <= 1'b0;
                        rd_ptr_reg    <= '0;
                        ev_valid_reg  <= 1'b0;
                        acc_reg       <= '0;
                        hit_reg       <= 1'b0;
                        bf_found_reg  <= 1'b0;
                        q_found_reg   <= 1'b0;
                        last_free_reg <= 1'b0;
                        need_reg      <= ARITH_W'(min_reg);
                        res_reg        <= '0;
                        res_reg.status <= bfsa_pkg::ST_BAD_ID;
                    end
                end
                bfsa_pkg::S_SCAN: begin
                    // one read issued and one entry evaluated per cycle
                    ev_valid_reg <= scan_issue;
                    ev_idx_reg   <= rd_ptr_reg[IDX_W-1:0];
                    if (scan_issue) begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    end
                    if (ev_valid_reg) begin
                        acc_reg       <= acc_next;
                        last_free_reg <= ev_ent.free;
                        last_size_reg <= ev_ent.size;
                        if (!hit_reg && own_hit) begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= ev_idx_reg;
                            hit_off_reg   <= acc_reg;
                            hit_size_reg  <= ev_ent.size;
                            hit_used_reg  <= ev_ent.used;
                            prev_free_reg <= (ev_idx_reg != '0) && last_free_reg;
                            prev_size_reg <= last_size_reg;
                        end
                        if (hit_reg && ev_idx_reg == hit_idx_reg + IDX_W'(1)) begin
                            next_free_reg <= ev_ent.free;
                            next_size_reg <= ev_ent.size;
                        end
                        if (bf_hit) begin
                            bf_found_reg <= 1'b1;
                            bf_idx_reg   <= ev_idx_reg;
                            bf_off_reg   <= acc_reg;
                            bf_size_reg  <= ev_ent.size;
                        end
                        if (!q_found_reg && q_hit) begin
                            q_found_reg <= 1'b1;
                            q_ent_reg   <= ev_ent;
                        end
                    end
                end
                bfsa_pkg::S_DECIDE: begin
                    plan_reg <= plan;
                    res_reg  <= plan.res;
                    if (plan.pass2) begin
                        // second scan for a free segment twice as big
                        pass2_reg    <= 1'b1;
                        need_reg     <= a_size << 1;
                        rd_ptr_reg   <= '0;
                        ev_valid_reg <= 1'b0;
                        acc_reg      <= '0;
                        bf_found_reg <= 1'b0;
                    end
                    // open a slot: entries from up_pos move up by one
                    sh_rd_reg   <= IDX_W'(count_reg - CNT_W'(1));
                    sh_left_reg <= plan.up_en ? (count_reg - CNT_W'(plan.up_pos)) : '0;
                    sh_wv_reg   <= 1'b0;
                end
                bfsa_pkg::S_SH_UP: begin
                    sh_wv_reg <= sh_left_reg != '0;
                    sh_wa_reg <= sh_rd_reg + IDX_W'(1);
                    if (sh_left_reg != '0) begin
                        sh_rd_reg   <= sh_rd_reg - IDX_W'(1);
                        sh_left_reg <= sh_left_reg - CNT_W'(1);
                    end
                end
                bfsa_pkg::S_WR_UP: begin
                    if (plan_reg.up_en) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                bfsa_pkg::S_WR2: begin
                    // close a slot: entries above dn_pos move down by one
                    sh_rd_reg   <= plan_reg.dn_pos + IDX_W'(1);
                    sh_left_reg <= plan_reg.dn_en ?
                                   (count_reg - CNT_W'(1) - CNT_W'(plan_reg.dn_pos)) : '0;
                    sh_wv_reg   <= 1'b0;
                end
                bfsa_pkg::S_SH_DN: begin
                    sh_wv_reg <= sh_left_reg != '0;
                    sh_wa_reg <= sh_rd_reg - IDX_W'(1);
                    if (sh_left_reg != '0) begin
                        sh_rd_reg   <= sh_rd_reg + IDX_W'(1);
                        sh_left_reg <= sh_left_reg - CNT_W'(1);
                    end
                    if (sh_done && plan_reg.dn_en) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                bfsa_pkg::S_APPEND: begin
                    if (plan_reg.ap_en) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                default: begin
                    sh_wv_reg <= 1'b0;
                end
            endcase

            // output register: a result can wait here while the next request runs
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == bfsa_pkg::S_DONE && (!out_valid_reg || m_ready)) begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfsa_ram.sv =====
`default_nettype none

module bfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bfsa_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module bfsa_chk (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire bfsa_pkg::res_t m_data
);

    logic err_seen;
    logic move_sum_ok;

    assign err_seen    = m_valid && (m_data.status != bfsa_pkg::ST_OK);
    assign move_sum_ok = m_data.record_offset ==
                         bfsa_pkg::OFF_W'(m_data.move_to + m_data.move_count);

    // stalled result holds
    `BFSA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // a failed request reports nothing but its status
    `BFSA_ASSERT_SAME(a_err_clean, aclk, aresetn, err_seen, m_data.record_offset == '0 && !m_data.move_valid && m_data.seg_owner == '0 && m_data.seg_lines == '0, "error result carries data")

    // a free segment has no owner and no records
    `BFSA_ASSERT_SAME(a_free_seg, aclk, aresetn, m_valid && m_data.seg_is_free, m_data.seg_owner == '0 && m_data.seg_used == '0, "free segment with owner or records")

    // after a move the new record follows the copied ones
    `BFSA_ASSERT_SAME(a_move_rec, aclk, aresetn, m_valid && m_data.move_valid, move_sum_ok, "record offset does not follow move")

endmodule

bind best_fit_segment_allocator_core bfsa_chk u_bfsa_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
